### hdl/path_length_accumulator_assert.svh
// Assertion macros used by the path length accumulator top level.
`ifndef PATH_LENGTH_ACCUMULATOR_ASSERT_SVH
`define PATH_LENGTH_ACCUMULATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define PLA_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PLA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PLA_ASSERT_SAME(name, clk, rst_n, ante, cons, msg)
`define PLA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

### hdl/pla_pkg.sv
// Shared widths, constants and a helper function of the path length accumulator.
package pla_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int DELTA_WIDTH = 21;
    localparam int TOTAL_WIDTH = 48;

    localparam int STEP_WIDTH = DELTA_WIDTH;
    localparam int SUM_WIDTH  = 2 * DELTA_WIDTH;
    localparam int CNT_WIDTH  = $clog2(DELTA_WIDTH);

    localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(DELTA_WIDTH - 1);

    localparam logic signed [COORD_WIDTH:0] DELTA_HI =
        (COORD_WIDTH + 1)'((64'd1 << (DELTA_WIDTH - 1)) - 64'd1);
    localparam logic signed [COORD_WIDTH:0] DELTA_LO = ~DELTA_HI;

    localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

    // Magnitude of the difference a - b after saturation to the delta range.
    function automatic logic [DELTA_WIDTH-1:0] sat_mag(
        input logic [COORD_WIDTH-1:0] a,
        input logic [COORD_WIDTH-1:0] b
    );
        logic signed [COORD_WIDTH:0] d;
        logic        [DELTA_WIDTH-1:0] s;
        d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
        if (d > DELTA_HI)
        begin
            s = DELTA_HI[DELTA_WIDTH-1:0];
        end
        else if (d < DELTA_LO)
        begin
            s = DELTA_LO[DELTA_WIDTH-1:0];
        end
        else
        begin
            s = d[DELTA_WIDTH-1:0];
        end
        return s[DELTA_WIDTH-1] ? DELTA_WIDTH'(~s + 1'b1) : s;
    endfunction

endpackage

### hdl/pla_pose_if.sv
// Input channel carrying one position transaction with its restart flag.
interface pla_pose_if import pla_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] pos_x;
    logic [COORD_WIDTH-1:0] pos_y;
    logic [COORD_WIDTH-1:0] pos_z;
    logic                   restart;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output restart, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input restart, output ready);

endinterface

### hdl/pla_dist_if.sv
// Output channel carrying one step length and cumulative length transaction.
interface pla_dist_if import pla_pkg::*; ();

    logic                   valid;
    logic                   ready;
    logic [STEP_WIDTH-1:0]  step_length;
    logic [TOTAL_WIDTH-1:0] total_length;

    modport source (output valid, output step_length, output total_length, input ready);
    modport sink   (input valid, input step_length, input total_length, output ready);

endinterface

### hdl/pla_sumsq.sv
// Serial-parallel unit that forms the sum of three squares, one multiplier bit per cycle.
module pla_sumsq import pla_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DELTA_WIDTH-1:0] mag_x,
    input  logic [DELTA_WIDTH-1:0] mag_y,
    input  logic [DELTA_WIDTH-1:0] mag_z,
    output logic                   busy,
    output logic                   done,
    output logic [SUM_WIDTH-1:0]   sum
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [DELTA_WIDTH-1:0] mx_reg, mx_next, my_reg, my_next, mz_reg, mz_next;
    logic [SUM_WIDTH-1:0]   ax_reg, ax_next, ay_reg, ay_next, az_reg, az_next;
    logic [SUM_WIDTH-1:0]   acc_reg, acc_next;
    logic [SUM_WIDTH-1:0]   partial;

    assign partial = (mx_reg[0] ? ax_reg : '0) + (my_reg[0] ? ay_reg : '0)
                   + (mz_reg[0] ? az_reg : '0);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mx_next   = mx_reg;
        my_next   = my_reg;
        mz_next   = mz_reg;
        ax_next   = ax_reg;
        ay_next   = ay_reg;
        az_next   = az_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            mx_next   = mag_x;
            my_next   = mag_y;
            mz_next   = mag_z;
            ax_next   = SUM_WIDTH'(mag_x);
            ay_next   = SUM_WIDTH'(mag_y);
            az_next   = SUM_WIDTH'(mag_z);
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + partial;
            mx_next  = mx_reg >> 1;
            my_next  = my_reg >> 1;
            mz_next  = mz_reg >> 1;
            ax_next  = ax_reg << 1;
            ay_next  = ay_reg << 1;
            az_next  = az_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg  <= mx_next;
        my_reg  <= my_next;
        mz_reg  <= mz_next;
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        az_reg  <= az_next;
        acc_reg <= acc_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign sum  = acc_reg;

endmodule

### hdl/pla_isqrt.sv
// Restoring integer square root that retires one root bit per cycle.
module pla_isqrt import pla_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SUM_WIDTH-1:0]   radicand,
    output logic                   busy,
    output logic                   done,
    output logic [DELTA_WIDTH-1:0] root
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [SUM_WIDTH-1:0]   rad_reg, rad_next;
    logic [DELTA_WIDTH:0]   rem_reg, rem_next;
    logic [DELTA_WIDTH-1:0] root_reg, root_next;
    logic [DELTA_WIDTH+2:0] rem_trial;
    logic [DELTA_WIDTH+2:0] trial;
    logic [DELTA_WIDTH+2:0] diff;
    logic                   fits;

    assign rem_trial = {rem_reg, rad_reg[SUM_WIDTH-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign fits      = rem_trial >= trial;
    assign diff      = rem_trial - trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[SUM_WIDTH-3:0], 2'b00};
            rem_next  = fits ? diff[DELTA_WIDTH:0] : rem_trial[DELTA_WIDTH:0];
            root_next = {root_reg[DELTA_WIDTH-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

### hdl/path_length_accumulator.sv
// Top level of the cumulative Euclidean path length accumulator.
//
//   channel  role    transaction contents
//   pose     sink    pos_x, pos_y, pos_z, restart
//   result   source  step_length, total_length
//
// A normal transaction runs from acceptance until pose is ready again through S_SQ, one
// pass of the bit-serial squarer, and S_ROOT, one pass of the bit-serial square root, each
// a bit per cycle, then S_OUT, which loads the output register once it is free.
// A restart or first transaction goes straight to S_OUT. The block takes one pose at a time.
// The result sits in an output register, so a stall on result holds only the last step.
// Reset clears the previous position, the running total and the control state.
module path_length_accumulator import pla_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    pla_pose_if.sink   pose,
    pla_dist_if.source result
);

    typedef enum logic [1:0] {S_IDLE, S_SQ, S_ROOT, S_OUT} state_t;

    state_t                 state_reg, state_next;
    logic                   have_prev_reg, have_prev_next;
    logic [COORD_WIDTH-1:0] prev_x_reg, prev_x_next;
    logic [COORD_WIDTH-1:0] prev_y_reg, prev_y_next;
    logic [COORD_WIDTH-1:0] prev_z_reg, prev_z_next;
    logic [TOTAL_WIDTH-1:0] total_reg, total_next;
    logic [STEP_WIDTH-1:0]  step_reg, step_next;
    logic                   out_valid_reg, out_valid_next;
    logic [STEP_WIDTH-1:0]  out_step_reg, out_step_next;
    logic [TOTAL_WIDTH-1:0] out_total_reg, out_total_next;

    logic                   accept;
    logic                   sq_start;
    logic                   sq_busy, sq_done;
    logic [SUM_WIDTH-1:0]   sq_sum;
    logic                   rt_busy, rt_done;
    logic [DELTA_WIDTH-1:0] rt_root;
    logic [DELTA_WIDTH-1:0] mag_x, mag_y, mag_z;
    logic [TOTAL_WIDTH:0]   total_sum;

    assign pose.ready = (state_reg == S_IDLE);
    assign accept     = pose.valid && pose.ready;
    assign sq_start   = accept && have_prev_reg && !pose.restart;

    assign mag_x = sat_mag(prev_x_reg, pose.pos_x);
    assign mag_y = sat_mag(prev_y_reg, pose.pos_y);
    assign mag_z = sat_mag(prev_z_reg, pose.pos_z);

    assign total_sum = {1'b0, total_reg} + (TOTAL_WIDTH + 1)'(rt_root);

    pla_sumsq u_sumsq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .mag_x (mag_x),
        .mag_y (mag_y),
        .mag_z (mag_z),
        .busy  (sq_busy),
        .done  (sq_done),
        .sum   (sq_sum)
    );

    pla_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_done),
        .radicand (sq_sum),
        .busy     (rt_busy),
        .done     (rt_done),
        .root     (rt_root)
    );

    always_comb
    begin
        state_next     = state_reg;
        have_prev_next = have_prev_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        prev_z_next    = prev_z_reg;
        total_next     = total_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_step_next  = out_step_reg;
        out_total_next = out_total_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    prev_x_next    = pose.pos_x;
                    prev_y_next    = pose.pos_y;
                    prev_z_next    = pose.pos_z;
                    have_prev_next = 1'b1;
                    if (sq_start)
                    begin
                        state_next = S_SQ;
                    end
                    else
                    begin
                        total_next = '0;
                        step_next  = '0;
                        state_next = S_OUT;
                    end
                end
            end
            S_SQ:
            begin
                if (sq_done)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (rt_done)
                begin
                    step_next  = rt_root;
                    total_next = total_sum[TOTAL_WIDTH] ? TOTAL_MAX
                                                        : total_sum[TOTAL_WIDTH-1:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_step_next  = step_reg;
                    out_total_next = total_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            have_prev_reg <= 1'b0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_z_reg    <= '0;
            total_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_step_reg  <= '0;
            out_total_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            have_prev_reg <= have_prev_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            prev_z_reg    <= prev_z_next;
            total_reg     <= total_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            out_step_reg  <= out_step_next;
            out_total_reg <= out_total_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.step_length  = out_step_reg;
    assign result.total_length = out_total_reg;

`include "path_length_accumulator_assert.svh"

    `PLA_ASSERT_SAME(a_sq_done_in_sq, clk, rst_n, sq_done, state_reg == S_SQ,
        "squarer finished outside its state")
    `PLA_ASSERT_SAME(a_rt_done_in_root, clk, rst_n, rt_done, state_reg == S_ROOT,
        "square root finished outside its state")
    `PLA_ASSERT_SAME(a_idle_units_quiet, clk, rst_n, pose.ready, !sq_busy && !rt_busy,
        "pose taken while a serial unit is busy")
    `PLA_ASSERT_NEXT(a_step_starts_squarer, clk, rst_n, sq_start, state_reg == S_SQ && sq_busy,
        "normal pose did not start the squarer")
    `PLA_ASSERT_SAME(a_total_covers_step, clk, rst_n, result.valid,
        result.total_length >= TOTAL_WIDTH'(result.step_length), "total below its own step")

endmodule

### sim/tb_path_length_accumulator.sv
// Testbench for the path length accumulator: directed and random pose streams checked against a scoreboard.
`timescale 1ns / 100ps

module tb_path_length_accumulator import pla_pkg::*; ();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_POSES = 1400;
    localparam int SAT_REACH = 1 << (DELTA_WIDTH - 1);

    typedef struct {
        logic [COORD_WIDTH-1:0] x;
        logic [COORD_WIDTH-1:0] y;
        logic [COORD_WIDTH-1:0] z;
        logic                   restart;
    } pose_t;

    typedef struct {
        logic [STEP_WIDTH-1:0]  step;
        logic [TOTAL_WIDTH-1:0] total;
    } distance_t;

    class path_scoreboard;
        logic [COORD_WIDTH-1:0] last_x;
        logic [COORD_WIDTH-1:0] last_y;
        logic [COORD_WIDTH-1:0] last_z;
        logic [TOTAL_WIDTH-1:0] distance_sum;
        bit                     seen_pose;
        distance_t              expected_q[$];
        int                     errors;

        function new();
            last_x = '0;
            last_y = '0;
            last_z = '0;
            distance_sum = '0;
            seen_pose = 0;
            errors = 0;
        endfunction

        function longint unsigned axis_square(logic [COORD_WIDTH-1:0] a,
                                              logic [COORD_WIDTH-1:0] b);
            longint diff;
            longint reach;
            reach = longint'(1) <<< (DELTA_WIDTH - 1);
            diff = longint'($signed(a)) - longint'($signed(b));
            if (diff > reach - 1)
            begin
                diff = reach - 1;
            end
            else if (diff < -reach)
            begin
                diff = -reach;
            end
            return longint'(diff * diff);
        endfunction

        function longint unsigned floor_root(longint unsigned n);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int i = STEP_WIDTH; i >= 0; i--)
            begin
                trial = root | (longint'(1) << i);
                if (trial * trial <= n)
                begin
                    root = trial;
                end
            end
            return root;
        endfunction

        function void note_pose(pose_t p);
            distance_t       e;
            longint unsigned sum_sq;
            e.step = '0;
            if (p.restart || !seen_pose)
            begin
                distance_sum = '0;
            end
            else
            begin
                sum_sq = axis_square(last_x, p.x) + axis_square(last_y, p.y)
                       + axis_square(last_z, p.z);
                e.step = STEP_WIDTH'(floor_root(sum_sq));
                if (distance_sum > TOTAL_MAX - TOTAL_WIDTH'(e.step))
                begin
                    distance_sum = TOTAL_MAX;
                end
                else
                begin
                    distance_sum = distance_sum + TOTAL_WIDTH'(e.step);
                end
            end
            e.total = distance_sum;
            last_x = p.x;
            last_y = p.y;
            last_z = p.z;
            seen_pose = 1;
            expected_q = {expected_q, e};
        endfunction

        function void check_distance(logic [STEP_WIDTH-1:0] step,
                                     logic [TOTAL_WIDTH-1:0] total);
            distance_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected transaction, step_length %0d total_length %0d",
                         $time, step, total);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (step !== e.step)
                begin
                    $display("%0t: step_length expected %0d actual %0d",
                             $time, e.step, step);
                    errors++;
                end
                if (total !== e.total)
                begin
                    $display("%0t: total_length expected %0d actual %0d",
                             $time, e.total, total);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic  clk;
    logic  rst_n;
    int    cycle_count = 0;
    pose_t directed_q[$];

    pla_pose_if pose ();
    pla_dist_if result ();

    path_scoreboard sb;

    path_length_accumulator u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .pose   (pose),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_path_length_accumulator: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pose.valid && pose.ready)
            begin
                sb.note_pose('{pose.pos_x, pose.pos_y, pose.pos_z, pose.restart});
            end
            if (result.valid && result.ready)
            begin
                sb.check_distance(result.step_length, result.total_length);
            end
        end
    end

    function automatic pose_t make_pose(logic [COORD_WIDTH-1:0] x,
                                        logic [COORD_WIDTH-1:0] y,
                                        logic [COORD_WIDTH-1:0] z,
                                        logic r);
        pose_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.restart = r;
        return p;
    endfunction

    function automatic void stage_pose(pose_t p);
        directed_q = {directed_q, p};
    endfunction

    function automatic logic [COORD_WIDTH-1:0] nudge(logic [COORD_WIDTH-1:0] base,
                                                     int unsigned span);
        int offset;
        offset = int'($urandom_range(0, 2 * span)) - int'(span);
        return base + COORD_WIDTH'(offset);
    endfunction

    function automatic logic [COORD_WIDTH-1:0] near_limit(logic [COORD_WIDTH-1:0] base);
        int offset;
        offset = SAT_REACH + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) == 1)
        begin
            offset = -offset;
        end
        return base + COORD_WIDTH'(offset);
    endfunction

    function automatic pose_t random_pose(pose_t last);
        pose_t       p;
        int unsigned kind;
        int unsigned span;
        kind = $urandom_range(0, 99);
        span = 1 << $urandom_range(0, 14);
        p = last;
        p.restart = 1'b0;
        if (kind < 5)
        begin
            p = make_pose(nudge(last.x, span), nudge(last.y, span), nudge(last.z, span), 1'b1);
        end
        else if (kind < 60)
        begin
            p.x = nudge(last.x, span);
            p.y = nudge(last.y, span);
            p.z = nudge(last.z, span);
        end
        else if (kind < 75)
        begin
            p.x = ($urandom_range(0, 1) == 1) ? near_limit(last.x) : nudge(last.x, span);
            p.y = ($urandom_range(0, 1) == 1) ? near_limit(last.y) : nudge(last.y, span);
            p.z = ($urandom_range(0, 1) == 1) ? near_limit(last.z) : nudge(last.z, span);
        end
        else if (kind < 88)
        begin
            p = make_pose($urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1)));
        end
        else if (kind < 93)
        begin
            p = last;
            p.restart = 1'b0;
        end
        else
        begin
            p.x = nudge(last.x, 3 * SAT_REACH);
            p.y = nudge(last.y, 3 * SAT_REACH);
            p.z = nudge(last.z, 3 * SAT_REACH);
        end
        return p;
    endfunction

    task automatic send_pose(pose_t p);
        @(negedge clk);
        pose.valid = 1'b1;
        pose.pos_x = p.x;
        pose.pos_y = p.y;
        pose.pos_z = p.z;
        pose.restart = p.restart;
        do
        begin
            @(posedge clk);
        end
        while (!pose.ready);
    endtask

    task automatic pause_sender(int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            pose.valid = 1'b0;
        end
    endtask

    task automatic drain_results();
        pause_sender(1);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int unsigned mode;
        int unsigned span;
        forever
        begin
            @(negedge clk);
            if (rst_n)
            begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(20, 300);
                repeat (span)
                begin
                    case (mode)
                        0: result.ready = 1'b1;
                        1: result.ready = ($urandom_range(0, 1) == 1);
                        default: result.ready = ($urandom_range(0, 11) == 0);
                    endcase
                    @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        pose_t       last;
        int unsigned burst;
        int          sent;
        logic [COORD_WIDTH-1:0] cmax;
        logic [COORD_WIDTH-1:0] cmin;

        sb = new();
        rst_n = 1'b0;
        pose.valid = 1'b0;
        pose.pos_x = '0;
        pose.pos_y = '0;
        pose.pos_z = '0;
        pose.restart = 1'b0;
        result.ready = 1'b0;
        cmax = {1'b0, {(COORD_WIDTH - 1){1'b1}}};
        cmin = {1'b1, {(COORD_WIDTH - 1){1'b0}}};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        stage_pose(make_pose(100, 200, 300, 1'b0));
        stage_pose(make_pose(103, 204, 300, 1'b0));
        stage_pose(make_pose(103, 204, 300, 1'b0));
        stage_pose(make_pose(104, 205, 301, 1'b0));
        stage_pose(make_pose(0, 0, 0, 1'b1));
        stage_pose(make_pose(SAT_REACH - 1, 0, 0, 1'b0));
        stage_pose(make_pose(-1, 0, 0, 1'b0));
        stage_pose(make_pose(SAT_REACH - 1, 0, 0, 1'b0));
        stage_pose(make_pose(-SAT_REACH - 1, SAT_REACH, -SAT_REACH, 1'b0));
        stage_pose(make_pose(cmax, cmax, cmax, 1'b0));
        stage_pose(make_pose(cmin, cmin, cmin, 1'b0));
        stage_pose(make_pose(cmax, cmax, cmax, 1'b0));
        stage_pose(make_pose(cmin, cmax, 0, 1'b1));
        stage_pose(make_pose(cmin + 5, cmax - 12, 0, 1'b0));
        stage_pose(make_pose(cmax, cmin, 7, 1'b0));
        stage_pose(make_pose(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 1'b0));
        stage_pose(make_pose(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 1'b0));
        stage_pose(make_pose(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0000, 1'b1));
        stage_pose(make_pose(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0400, 1'b0));
        stage_pose(make_pose(32'h5555_5556, 32'hAAAA_AAAB, 32'h0000_0401, 1'b0));
        stage_pose(make_pose(32'h5555_5556, 32'hAAAA_AAAB, 32'hFFFF_FC01, 1'b0));

        foreach (directed_q[i])
        begin
            send_pose(directed_q[i]);
            pause_sender($urandom_range(0, 3));
        end
        last = directed_q[directed_q.size() - 1];
        drain_results();

        sent = 0;
        while (sent < RANDOM_POSES)
        begin
            burst = $urandom_range(1, 16);
            while (burst > 0 && sent < RANDOM_POSES)
            begin
                last = random_pose(last);
                send_pose(last);
                sent++;
                burst--;
                if (sent == RANDOM_POSES / 2)
                begin
                    drain_results();
                end
            end
            if ($urandom_range(0, 3) != 0)
            begin
                pause_sender($urandom_range(1, 40));
            end
        end

        drain_results();
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("tb_path_length_accumulator: PASS");
        end
        else
        begin
            $display("tb_path_length_accumulator: FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hdl
hdl/pla_pkg.sv
hdl/pla_pose_if.sv
hdl/pla_dist_if.sv
hdl/pla_sumsq.sv
hdl/pla_isqrt.sv
hdl/path_length_accumulator.sv
sim/tb_path_length_accumulator.sv
